>>> hdl/iast_pkg.sv
// ============================================================================
// iast_pkg - shared types and constants of the source tokenizer
// Request and response payloads, the internal command format that travels
// from the scanner to the emitter, token codes and character classes.
// ============================================================================
package iast_pkg;

   // Request kind codes
   localparam logic KIND_TEXT = 1'b0;
   localparam logic KIND_END  = 1'b1;

   // Token codes
   localparam logic [2:0] TOK_INDENT = 3'd0;
   localparam logic [2:0] TOK_IDENT  = 3'd1;
   localparam logic [2:0] TOK_NUMBER = 3'd2;
   localparam logic [2:0] TOK_SYMBOL = 3'd3;
   localparam logic [2:0] TOK_END    = 3'd4;
   localparam logic [2:0] TOK_ERROR  = 3'd5;

   // Saturation limits
   localparam logic [30:0] NUM_MAX = 31'h7FFF_FFFF;
   localparam logic [15:0] IND_MAX = 16'hFFFF;

   // Characters with a role of their own
   localparam logic [7:0] CH_NL     = 8'd10;
   localparam logic [7:0] CH_TAB    = 8'd9;
   localparam logic [7:0] CH_VT     = 8'd11;
   localparam logic [7:0] CH_FF     = 8'd12;
   localparam logic [7:0] CH_CR     = 8'd13;
   localparam logic [7:0] CH_SPACE  = 8'h20;
   localparam logic [7:0] CH_HASH   = 8'h23;
   localparam logic [7:0] CH_BAR    = 8'h7C;
   localparam logic [7:0] CH_AMP    = 8'h26;
   localparam logic [7:0] CH_EQ     = 8'h3D;
   localparam logic [7:0] CH_BANG   = 8'h21;
   localparam logic [7:0] CH_LT     = 8'h3C;
   localparam logic [7:0] CH_GT     = 8'h3E;
   localparam logic [7:0] CH_LPAREN = 8'h28;
   localparam logic [7:0] CH_RPAREN = 8'h29;
   localparam logic [7:0] CH_SLASH  = 8'h2F;
   localparam logic [7:0] CH_STAR   = 8'h2A;
   localparam logic [7:0] CH_MINUS  = 8'h2D;
   localparam logic [7:0] CH_PLUS   = 8'h2B;
   localparam logic [7:0] CH_CARET  = 8'h5E;
   localparam logic [7:0] CH_COLON  = 8'h3A;
   localparam logic [7:0] CH_COMMA  = 8'h2C;
   localparam logic [7:0] CH_LBRACK = 8'h5B;
   localparam logic [7:0] CH_RBRACK = 8'h5D;

   // Scanner modes
   typedef enum logic [2:0] {
      MODE_LINE_START,
      MODE_IN_LINE,
      MODE_IDENT,
      MODE_NUMBER,
      MODE_SWALLOW,
      MODE_PENDING,
      MODE_COMMENT
   } mode_type;

   // Emitter states
   typedef enum logic [1:0] {
      BK_IDLE,
      BK_READ,
      BK_DATA
   } bk_state_type;

   typedef struct packed {
      logic       kind;
      logic [7:0] ch;
   } req_type;

   typedef struct packed {
      logic [2:0]  tok_type;
      logic [30:0] value;
      logic [7:0]  ch1;
      logic [7:0]  ch2;
      logic        last;
      logic        truncated;
   } rsp_type;

   // Scanner-to-emitter command. A flush command carries the identifier
   // length in value and the overflow flag in trunc.
   typedef struct packed {
      logic        is_flush;
      logic [2:0]  tok_type;
      logic [30:0] value;
      logic [7:0]  ch1;
      logic [7:0]  ch2;
      logic        trunc;
   } cmd_type;

   typedef struct packed {
      logic flush_done;
   } bk_status_type;

   function automatic logic is_letter(input logic [7:0] c);
      return ((c >= 8'h41) && (c <= 8'h5A)) || ((c >= 8'h61) && (c <= 8'h7A));
   endfunction

   function automatic logic is_digit(input logic [7:0] c);
      return (c >= 8'h30) && (c <= 8'h39);
   endfunction

   function automatic logic is_blank(input logic [7:0] c);
      return (c == CH_SPACE) || (c == CH_TAB) || (c == CH_VT) ||
             (c == CH_FF) || (c == CH_CR);
   endfunction

   function automatic logic is_single_sym(input logic [7:0] c);
      return (c == CH_LPAREN) || (c == CH_RPAREN) || (c == CH_SLASH) ||
             (c == CH_STAR) || (c == CH_MINUS) || (c == CH_PLUS) ||
             (c == CH_CARET) || (c == CH_COLON) || (c == CH_COMMA) ||
             (c == CH_LBRACK) || (c == CH_RBRACK);
   endfunction

   function automatic logic is_pair_sym(input logic [7:0] c);
      return (c == CH_BAR) || (c == CH_AMP) || (c == CH_BANG) ||
             (c == CH_LT) || (c == CH_GT) || (c == CH_EQ);
   endfunction

   // Mode entered when a byte is scanned as a fresh token start
   function automatic mode_type start_mode(input logic [7:0] c);
      mode_type m;
      if (c == CH_NL) begin
         m = MODE_LINE_START;
      end else if (c == CH_HASH) begin
         m = MODE_COMMENT;
      end else if (is_letter(c)) begin
         m = MODE_IDENT;
      end else if (is_digit(c)) begin
         m = MODE_NUMBER;
      end else if (is_pair_sym(c)) begin
         m = MODE_PENDING;
      end else begin
         m = MODE_IN_LINE;
      end
      return m;
   endfunction

   function automatic cmd_type mk_tok(input logic [2:0] t, input logic [30:0] v,
                                      input logic [7:0] c1, input logic [7:0] c2);
      cmd_type r;
      r.is_flush = 1'b0;
      r.tok_type = t;
      r.value    = v;
      r.ch1      = c1;
      r.ch2      = c2;
      r.trunc    = 1'b0;
      return r;
   endfunction

   function automatic cmd_type mk_flush(input logic [30:0] len, input logic ovf);
      cmd_type r;
      r.is_flush = 1'b1;
      r.tok_type = TOK_IDENT;
      r.value    = len;
      r.ch1      = 8'd0;
      r.ch2      = 8'd0;
      r.trunc    = ovf;
      return r;
   endfunction

endpackage

>>> hdl/iast_ram.sv
// ============================================================================
// iast_ram - generic single-write, single-read RAM
// One write port and one read port; read data is registered on read enable.
// ============================================================================
module iast_ram #(
   parameter int  WIDTH = 8,
   parameter int  DEPTH = 32,
   localparam int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
   input  logic             clock,
   input  logic             wr_en,
   input  logic [AW-1:0]    wr_addr,
   input  logic [WIDTH-1:0] wr_data,
   input  logic             rd_en,
   input  logic [AW-1:0]    rd_addr,
   output logic [WIDTH-1:0] rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   // Storage and registered read
   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem_ff[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

>>> hdl/iast_front.sv
// ============================================================================
// iast_front - byte scanner
// Accepts one request, classifies it against the scan mode, updates the line
// state and the identifier buffer, and plans up to three commands that it
// hands to the command queue one per cycle while the queue is not full.
// ============================================================================
module iast_front #(
   parameter int  MAX_IDENT_LEN = 32,
   localparam int AW    = (MAX_IDENT_LEN > 1) ? $clog2(MAX_IDENT_LEN) : 1,
   localparam int LEN_W = $clog2(MAX_IDENT_LEN + 1)
) (
   input  logic                     clock,
   input  logic                     reset,
   input  logic                     req_valid,
   output logic                     req_stall,
   input  iast_pkg::req_type        req_data,
   output logic                     q_push,
   output iast_pkg::cmd_type        q_data,
   input  logic                     q_full,
   input  iast_pkg::bk_status_type  bk_status,
   output logic                     buf_wr_en,
   output logic [AW-1:0]            buf_wr_addr,
   output logic [7:0]               buf_wr_data
);

   iast_pkg::mode_type mode_ff, mode_in;
   logic [15:0]        indent_ff, indent_in;
   logic [30:0]        num_ff, num_in;
   logic [7:0]         pend_ff, pend_in;
   logic [LEN_W-1:0]   len_ff, len_in;
   logic               ovf_ff, ovf_in;
   logic               flush_busy_ff, flush_busy_in;
   iast_pkg::cmd_type  plan_ff [3];
   iast_pkg::cmd_type  plan_in [3];
   logic [1:0]         plan_cnt_ff, plan_cnt_in;

   iast_pkg::cmd_type  cmds [3];
   logic [1:0]         n_cmd;
   logic               has_flush;
   logic               accept;
   logic               inl_go;
   logic [7:0]         c;
   logic               alnum;
   logic [34:0]        num_wide;

   assign c       = req_data.ch;
   assign alnum   = iast_pkg::is_letter(c) || iast_pkg::is_digit(c);
   assign accept  = req_valid && !req_stall;
   assign req_stall = (plan_cnt_ff != 2'd0) || flush_busy_ff;

   // Decimal step: accum * 10 + digit
   assign num_wide = ({4'd0, num_ff} << 3) + ({4'd0, num_ff} << 1) + 35'(c[3:0]);

   // Does the byte get scanned as the start of a new token
   always_comb begin
      inl_go = 1'b0;
      if (req_data.kind == iast_pkg::KIND_TEXT) begin
         unique case (mode_ff)
            iast_pkg::MODE_LINE_START: begin
               inl_go = (c != iast_pkg::CH_NL) && !iast_pkg::is_blank(c) &&
                        (c != iast_pkg::CH_HASH);
            end
            iast_pkg::MODE_IDENT,
            iast_pkg::MODE_SWALLOW: begin
               inl_go = !alnum;
            end
            iast_pkg::MODE_NUMBER: begin
               inl_go = !alnum;
            end
            iast_pkg::MODE_PENDING: begin
               if ((pend_ff == iast_pkg::CH_BAR) || (pend_ff == iast_pkg::CH_AMP)) begin
                  inl_go = (c == iast_pkg::CH_NL) || (c == iast_pkg::CH_HASH);
               end else begin
                  inl_go = (c != iast_pkg::CH_EQ);
               end
            end
            iast_pkg::MODE_COMMENT: begin
               inl_go = 1'b0;
            end
            iast_pkg::MODE_IN_LINE: begin
               inl_go = 1'b1;
            end
            default: begin
               inl_go = 1'b1;
            end
         endcase
      end
   end

   // Scan mode next state
   always_comb begin
      mode_in = mode_ff;
      if (accept) begin
         if (req_data.kind == iast_pkg::KIND_END) begin
            mode_in = iast_pkg::MODE_LINE_START;
         end else if (inl_go) begin
            mode_in = iast_pkg::start_mode(c);
         end else begin
            unique case (mode_ff)
               iast_pkg::MODE_LINE_START: begin
                  if (c == iast_pkg::CH_HASH) begin
                     mode_in = iast_pkg::MODE_COMMENT;
                  end
               end
               iast_pkg::MODE_NUMBER: begin
                  if (iast_pkg::is_letter(c)) begin
                     mode_in = iast_pkg::MODE_SWALLOW;
                  end
               end
               iast_pkg::MODE_PENDING: begin
                  mode_in = iast_pkg::MODE_IN_LINE;
               end
               iast_pkg::MODE_COMMENT: begin
                  if (c == iast_pkg::CH_NL) begin
                     mode_in = iast_pkg::MODE_LINE_START;
                  end
               end
               default: begin
                  mode_in = mode_ff;
               end
            endcase
         end
      end
   end

   // Line state, buffer writes and planned commands
   always_comb begin
      indent_in   = indent_ff;
      num_in      = num_ff;
      pend_in     = pend_ff;
      len_in      = len_ff;
      ovf_in      = ovf_ff;
      buf_wr_en   = 1'b0;
      buf_wr_addr = len_ff[AW-1:0];
      buf_wr_data = c;
      has_flush   = 1'b0;
      n_cmd       = 2'd0;
      for (int i = 0; i < 3; i++) begin
         cmds[i] = '0;
      end

      if (req_data.kind == iast_pkg::KIND_END) begin
         // flush the open token, then indent zero and terminator
         unique case (mode_ff)
            iast_pkg::MODE_IDENT: begin
               cmds[n_cmd] = iast_pkg::mk_flush(31'(len_ff), ovf_ff);
               n_cmd       = n_cmd + 2'd1;
               has_flush   = 1'b1;
            end
            iast_pkg::MODE_NUMBER,
            iast_pkg::MODE_SWALLOW: begin
               cmds[n_cmd] = iast_pkg::mk_tok(iast_pkg::TOK_NUMBER, num_ff, 8'd0, 8'd0);
               n_cmd       = n_cmd + 2'd1;
            end
            iast_pkg::MODE_PENDING: begin
               cmds[n_cmd] = iast_pkg::mk_tok(iast_pkg::TOK_SYMBOL, 31'd0, pend_ff, 8'd0);
               n_cmd       = n_cmd + 2'd1;
            end
            default: begin
               n_cmd = n_cmd;
            end
         endcase
         cmds[n_cmd] = iast_pkg::mk_tok(iast_pkg::TOK_INDENT, 31'd0, 8'd0, 8'd0);
         n_cmd       = n_cmd + 2'd1;
         cmds[n_cmd] = iast_pkg::mk_tok(iast_pkg::TOK_END, 31'd0, 8'd0, 8'd0);
         n_cmd       = n_cmd + 2'd1;
         indent_in   = '0;
         num_in      = '0;
         pend_in     = '0;
         len_in      = '0;
         ovf_in      = 1'b0;
      end else begin
         // continuation of the current mode
         unique case (mode_ff)
            iast_pkg::MODE_LINE_START: begin
               if (c == iast_pkg::CH_NL) begin
                  indent_in = '0;
               end else if (c == iast_pkg::CH_SPACE) begin
                  if (indent_ff != iast_pkg::IND_MAX) begin
                     indent_in = indent_ff + 16'd1;
                  end
               end else if (inl_go) begin
                  cmds[n_cmd] = iast_pkg::mk_tok(iast_pkg::TOK_INDENT, 31'(indent_ff),
                                                 8'd0, 8'd0);
                  n_cmd       = n_cmd + 2'd1;
                  indent_in   = '0;
               end
            end
            iast_pkg::MODE_IDENT: begin
               if (alnum) begin
                  if (len_ff < LEN_W'(MAX_IDENT_LEN)) begin
                     buf_wr_en = 1'b1;
                     len_in    = len_ff + LEN_W'(1);
                  end else begin
                     ovf_in = 1'b1;
                  end
               end else begin
                  cmds[n_cmd] = iast_pkg::mk_flush(31'(len_ff), ovf_ff);
                  n_cmd       = n_cmd + 2'd1;
                  has_flush   = 1'b1;
                  len_in      = '0;
                  ovf_in      = 1'b0;
               end
            end
            iast_pkg::MODE_NUMBER: begin
               if (iast_pkg::is_digit(c)) begin
                  num_in = (num_wide > 35'(iast_pkg::NUM_MAX)) ? iast_pkg::NUM_MAX
                                                                : num_wide[30:0];
               end else if (!iast_pkg::is_letter(c)) begin
                  cmds[n_cmd] = iast_pkg::mk_tok(iast_pkg::TOK_NUMBER, num_ff, 8'd0, 8'd0);
                  n_cmd       = n_cmd + 2'd1;
                  num_in      = '0;
               end
            end
            iast_pkg::MODE_SWALLOW: begin
               if (!alnum) begin
                  cmds[n_cmd] = iast_pkg::mk_tok(iast_pkg::TOK_NUMBER, num_ff, 8'd0, 8'd0);
                  n_cmd       = n_cmd + 2'd1;
                  num_in      = '0;
               end
            end
            iast_pkg::MODE_PENDING: begin
               pend_in = '0;
               if (inl_go) begin
                  cmds[n_cmd] = iast_pkg::mk_tok(iast_pkg::TOK_SYMBOL, 31'd0, pend_ff, 8'd0);
               end else begin
                  cmds[n_cmd] = iast_pkg::mk_tok(iast_pkg::TOK_SYMBOL, 31'd0, pend_ff, c);
               end
               n_cmd = n_cmd + 2'd1;
            end
            iast_pkg::MODE_COMMENT: begin
               if (c == iast_pkg::CH_NL) begin
                  indent_in = '0;
               end
            end
            default: begin
               n_cmd = n_cmd;
            end
         endcase

         // byte scanned as a token start
         if (inl_go) begin
            if (c == iast_pkg::CH_NL) begin
               indent_in = '0;
            end else if ((c == iast_pkg::CH_HASH) || iast_pkg::is_blank(c)) begin
               n_cmd = n_cmd;
            end else if (iast_pkg::is_letter(c)) begin
               buf_wr_en   = 1'b1;
               buf_wr_addr = '0;
               len_in      = LEN_W'(1);
               ovf_in      = 1'b0;
            end else if (iast_pkg::is_digit(c)) begin
               num_in = 31'(c[3:0]);
            end else if (iast_pkg::is_single_sym(c)) begin
               cmds[n_cmd] = iast_pkg::mk_tok(iast_pkg::TOK_SYMBOL, 31'd0, c, 8'd0);
               n_cmd       = n_cmd + 2'd1;
            end else if (iast_pkg::is_pair_sym(c)) begin
               pend_in = c;
            end else begin
               cmds[n_cmd] = iast_pkg::mk_tok(iast_pkg::TOK_ERROR, 31'd0, c, 8'd0);
               n_cmd       = n_cmd + 2'd1;
            end
         end
      end

      if (!accept) begin
         buf_wr_en = 1'b0;
      end
   end

   // Plan holding: load on accept, drain one command per cycle while the queue is not full
   assign q_push = (plan_cnt_ff != 2'd0) && !q_full;
   assign q_data = plan_ff[0];

   always_comb begin
      plan_in     = plan_ff;
      plan_cnt_in = plan_cnt_ff;
      if (accept) begin
         plan_in     = cmds;
         plan_cnt_in = n_cmd;
      end else if (q_push) begin
         plan_in[0]  = plan_ff[1];
         plan_in[1]  = plan_ff[2];
         plan_cnt_in = plan_cnt_ff - 2'd1;
      end
   end

   // Identifier buffer is owned by the emitter while a flush is outstanding
   always_comb begin
      flush_busy_in = flush_busy_ff;
      if (bk_status.flush_done) begin
         flush_busy_in = 1'b0;
      end
      if (accept && has_flush) begin
         flush_busy_in = 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         mode_ff       <= iast_pkg::MODE_LINE_START;
         indent_ff     <= '0;
         num_ff        <= '0;
         pend_ff       <= '0;
         len_ff        <= '0;
         ovf_ff        <= 1'b0;
         flush_busy_ff <= 1'b0;
         plan_cnt_ff   <= '0;
      end else begin
         mode_ff       <= mode_in;
         flush_busy_ff <= flush_busy_in;
         plan_cnt_ff   <= plan_cnt_in;
         if (accept) begin
            indent_ff <= indent_in;
            num_ff    <= num_in;
            pend_ff   <= pend_in;
            len_ff    <= len_in;
            ovf_ff    <= ovf_in;
         end
      end
   end

   always_ff @(posedge clock) begin
      plan_ff <= plan_in;
   end

endmodule

>>> hdl/iast_queue.sv
// ============================================================================
// iast_queue - two-entry command queue
// Decouples the scanner from the emitter so that either side can stall.
// ============================================================================
module iast_queue (
   input  logic              clock,
   input  logic              reset,
   input  logic              push,
   input  iast_pkg::cmd_type push_data,
   output logic              full,
   input  logic              pop,
   output iast_pkg::cmd_type head,
   output logic              empty
);

   iast_pkg::cmd_type entry_ff [2];
   logic              wr_ptr_ff, wr_ptr_in;
   logic              rd_ptr_ff, rd_ptr_in;
   logic [1:0]        count_ff, count_in;
   logic              do_push;
   logic              do_pop;

   assign full    = (count_ff == 2'd2);
   assign empty   = (count_ff == 2'd0);
   assign head    = entry_ff[rd_ptr_ff];
   assign do_push = push && !full;
   assign do_pop  = pop && !empty;

   // Pointer and occupancy update
   always_comb begin
      wr_ptr_in = do_push ? ~wr_ptr_ff : wr_ptr_ff;
      rd_ptr_in = do_pop ? ~rd_ptr_ff : rd_ptr_ff;
      count_in  = count_ff;
      if (do_push && !do_pop) begin
         count_in = count_ff + 2'd1;
      end else if (do_pop && !do_push) begin
         count_in = count_ff - 2'd1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= 1'b0;
         rd_ptr_ff <= 1'b0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (do_push) begin
         entry_ff[wr_ptr_ff] <= push_data;
      end
   end

endmodule

>>> hdl/iast_back.sv
// ============================================================================
// iast_back - token emitter
// Takes commands from the queue into the response register. A flush command
// walks the identifier buffer and sends one response per character.
// ============================================================================
module iast_back #(
   parameter int  MAX_IDENT_LEN = 32,
   localparam int AW    = (MAX_IDENT_LEN > 1) ? $clog2(MAX_IDENT_LEN) : 1,
   localparam int LEN_W = $clog2(MAX_IDENT_LEN + 1)
) (
   input  logic                    clock,
   input  logic                    reset,
   input  logic                    q_empty,
   input  iast_pkg::cmd_type       q_head,
   output logic                    q_pop,
   output logic                    buf_rd_en,
   output logic [AW-1:0]           buf_rd_addr,
   input  logic [7:0]              buf_rd_data,
   output iast_pkg::bk_status_type bk_status,
   output logic                    rsp_valid,
   input  logic                    rsp_stall,
   output iast_pkg::rsp_type       rsp_data
);

   iast_pkg::bk_state_type state_ff, state_in;
   logic [LEN_W-1:0]       cnt_ff, cnt_in;
   logic [LEN_W-1:0]       len_ff;
   logic                   trunc_ff;
   logic                   rsp_valid_ff, rsp_valid_in;
   iast_pkg::rsp_type      rsp_data_ff, rsp_data_in;

   logic out_free;
   logic is_last;
   logic load_tok;
   logic load_chr;
   logic take_flush;

   assign out_free = !rsp_valid_ff || !rsp_stall;
   assign is_last  = ((cnt_ff + LEN_W'(1)) == len_ff);

   // Next state
   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         iast_pkg::BK_IDLE: begin
            if (!q_empty && q_head.is_flush) begin
               state_in = iast_pkg::BK_READ;
            end
         end
         iast_pkg::BK_READ: begin
            state_in = iast_pkg::BK_DATA;
         end
         iast_pkg::BK_DATA: begin
            if (out_free) begin
               state_in = is_last ? iast_pkg::BK_IDLE : iast_pkg::BK_READ;
            end
         end
         default: begin
            state_in = iast_pkg::BK_IDLE;
         end
      endcase
   end

   // Control outputs
   always_comb begin
      take_flush  = 1'b0;
      load_tok    = 1'b0;
      load_chr    = 1'b0;
      buf_rd_en   = 1'b0;
      unique case (state_ff)
         iast_pkg::BK_IDLE: begin
            take_flush = !q_empty && q_head.is_flush;
            load_tok   = !q_empty && !q_head.is_flush && out_free;
         end
         iast_pkg::BK_READ: begin
            buf_rd_en = 1'b1;
         end
         iast_pkg::BK_DATA: begin
            load_chr = out_free;
         end
         default: begin
            take_flush = 1'b0;
         end
      endcase
   end

   assign q_pop                = take_flush || load_tok;
   assign buf_rd_addr          = cnt_ff[AW-1:0];
   assign bk_status.flush_done = load_chr && is_last;

   // Character counter
   always_comb begin
      cnt_in = cnt_ff;
      if (take_flush) begin
         cnt_in = '0;
      end else if (load_chr && !is_last) begin
         cnt_in = cnt_ff + LEN_W'(1);
      end
   end

   // Response register
   always_comb begin
      rsp_valid_in = rsp_valid_ff;
      rsp_data_in  = rsp_data_ff;
      if (load_tok) begin
         rsp_valid_in          = 1'b1;
         rsp_data_in.tok_type  = q_head.tok_type;
         rsp_data_in.value     = q_head.value;
         rsp_data_in.ch1       = q_head.ch1;
         rsp_data_in.ch2       = q_head.ch2;
         rsp_data_in.last      = 1'b1;
         rsp_data_in.truncated = 1'b0;
      end else if (load_chr) begin
         rsp_valid_in          = 1'b1;
         rsp_data_in.tok_type  = iast_pkg::TOK_IDENT;
         rsp_data_in.value     = '0;
         rsp_data_in.ch1       = buf_rd_data;
         rsp_data_in.ch2       = '0;
         rsp_data_in.last      = is_last;
         rsp_data_in.truncated = trunc_ff;
      end else if (!rsp_stall) begin
         rsp_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= iast_pkg::BK_IDLE;
         cnt_ff       <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         cnt_ff       <= cnt_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      rsp_data_ff <= rsp_data_in;
      if (take_flush) begin
         len_ff   <= q_head.value[LEN_W-1:0];
         trunc_ff <= q_head.trunc;
      end
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_data_ff;

endmodule

>>> hdl/indent_aware_source_tokenizer_core.sv
// ============================================================================
// indent_aware_source_tokenizer_core - line-oriented source tokenizer
// Scanner, command queue, identifier buffer and token emitter.
// ============================================================================
// Source bytes come in as requests (kind 0 with the byte, kind 1 for end of
// input) and tokens leave as responses: an indent token per line that is
// neither blank nor comment-only, identifiers one character per response,
// saturating decimal numbers, one/two-character symbols, error tokens for
// stray bytes, and on end of input an indent-zero and an end token. A request
// that yields commands holds off the next one while the scanner hands them to
// the queue, one per cycle while the queue is not full. A finished identifier
// is read from the buffer RAM character by character, each read registered
// before it is sent, and the next request is held off until that read-out ends,
// because the buffer has a single write and a single read port.
// ============================================================================
module indent_aware_source_tokenizer_core #(
   parameter int MAX_IDENT_LEN = 32
) (
   input  logic              clock,
   input  logic              reset,
   input  logic              req_valid,
   output logic              req_stall,
   input  iast_pkg::req_type req_data,
   output logic              rsp_valid,
   input  logic              rsp_stall,
   output iast_pkg::rsp_type rsp_data
);

   localparam int AW = (MAX_IDENT_LEN > 1) ? $clog2(MAX_IDENT_LEN) : 1;

   logic                    q_push;
   iast_pkg::cmd_type       q_push_data;
   logic                    q_full;
   logic                    q_pop;
   iast_pkg::cmd_type       q_head;
   logic                    q_empty;
   iast_pkg::bk_status_type bk_status;
   logic                    buf_wr_en;
   logic [AW-1:0]           buf_wr_addr;
   logic [7:0]              buf_wr_data;
   logic                    buf_rd_en;
   logic [AW-1:0]           buf_rd_addr;
   logic [7:0]              buf_rd_data;

   // Scanner
   iast_front #(
      .MAX_IDENT_LEN (MAX_IDENT_LEN)
   ) u_front (
      .clock       (clock),
      .reset       (reset),
      .req_valid   (req_valid),
      .req_stall   (req_stall),
      .req_data    (req_data),
      .q_push      (q_push),
      .q_data      (q_push_data),
      .q_full      (q_full),
      .bk_status   (bk_status),
      .buf_wr_en   (buf_wr_en),
      .buf_wr_addr (buf_wr_addr),
      .buf_wr_data (buf_wr_data)
   );

   // Command queue
   iast_queue u_queue (
      .clock     (clock),
      .reset     (reset),
      .push      (q_push),
      .push_data (q_push_data),
      .full      (q_full),
      .pop       (q_pop),
      .head      (q_head),
      .empty     (q_empty)
   );

   // Identifier buffer
   iast_ram #(
      .WIDTH (8),
      .DEPTH (MAX_IDENT_LEN)
   ) u_ident_buf (
      .clock   (clock),
      .wr_en   (buf_wr_en),
      .wr_addr (buf_wr_addr),
      .wr_data (buf_wr_data),
      .rd_en   (buf_rd_en),
      .rd_addr (buf_rd_addr),
      .rd_data (buf_rd_data)
   );

   // Emitter
   iast_back #(
      .MAX_IDENT_LEN (MAX_IDENT_LEN)
   ) u_back (
      .clock       (clock),
      .reset       (reset),
      .q_empty     (q_empty),
      .q_head      (q_head),
      .q_pop       (q_pop),
      .buf_rd_en   (buf_rd_en),
      .buf_rd_addr (buf_rd_addr),
      .buf_rd_data (buf_rd_data),
      .bk_status   (bk_status),
      .rsp_valid   (rsp_valid),
      .rsp_stall   (rsp_stall),
      .rsp_data    (rsp_data)
   );

endmodule
